// ===== src/msaa_zbuffer_fragment_macros.svh =====
// assertion macros for the msaa z-buffer fragment block
// used by the checker module only
`ifndef MSAA_ZBUFFER_FRAGMENT_MACROS_SVH
`define MSAA_ZBUFFER_FRAGMENT_MACROS_SVH
`define MZB_ASSERT_IMPL(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MZB_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== src/mzb_pkg.sv =====
// shared types and constants for the msaa z-buffer fragment block
// no dependencies
package mzb_pkg;
    localparam int ScreenWidth  = 256;
    localparam int ScreenHeight = 256;
    localparam int XW = $clog2(ScreenWidth);
    localparam int YW = $clog2(ScreenHeight);
    localparam int PixCount = ScreenWidth * ScreenHeight;
    localparam int PW = $clog2(PixCount);
    localparam int SampW = PW + 2;

    typedef struct packed {
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic signed [15:0] vert_a_x;
        logic signed [15:0] vert_a_y;
        logic signed [15:0] vert_a_z;
        logic signed [15:0] vert_b_x;
        logic signed [15:0] vert_b_y;
        logic signed [15:0] vert_b_z;
        logic signed [15:0] vert_c_x;
        logic signed [15:0] vert_c_y;
        logic signed [15:0] vert_c_z;
        logic [23:0]        tri_color;
    } frag_in_t;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [9:0] red_sum;
        logic [9:0] green_sum;
        logic [9:0] blue_sum;
        logic [2:0] samples_updated;
    } frag_out_t;

    typedef enum logic [5:0] {
        CMD_NONE   = 6'b000001,
        CMD_CLEAR  = 6'b000010,
        CMD_LOAD   = 6'b000100,
        CMD_SETUP  = 6'b001000,
        CMD_READ   = 6'b010000,
        CMD_SAMPLE = 6'b100000
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t    cmd;
        logic [1:0] step;
        logic       div_start;
    } dp_ctl_t;

    typedef struct packed {
        logic reject;
        logic div_done;
        logic any_update;
        logic clear_done;
    } dp_sts_t;
endpackage

// ===== src/mzb_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle, rounds and saturates
// depends on mzb_pkg
module mzb_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [15:0] quot
);
    import mzb_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic signed [15:0] quot_reg, quot_next;
    logic [63:0] an, ad, sh;
    logic        nneg;

    always_comb
    begin
        nneg = num[63] ^ den[63];
        an = num[63] ? 64'(-num) : 64'(num);
        ad = den[63] ? 64'(-den) : 64'(den);
        rem_next = rem_reg;
        q_next = q_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        sh = {rem_reg[62:0], q_reg[63]};
        if (start)
        begin
            rem_next = 64'd0;
            q_next = an + {1'b0, ad[63:1]};
            d_next = ad;
            neg_next = nneg;
            cnt_next = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= d_reg)
            begin
                rem_next = sh - d_reg;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    quot_next = (q_next >= 64'd32768) ? 16'sh8000 : 16'(-q_next);
                else
                    quot_next = (q_next >= 64'd32767) ? 16'sh7fff : 16'(q_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ===== src/mzb_datapath.sv =====
// datapath: edge setup, depth divider, sample memories and color sums
// depends on mzb_pkg and mzb_divider
module mzb_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  mzb_pkg::frag_in_t frag_in,
    input  mzb_pkg::dp_ctl_t  ctl,
    output mzb_pkg::dp_sts_t  sts,
    output mzb_pkg::frag_out_t frag_out
);
    import mzb_pkg::*;

    frag_in_t f_reg;
    logic signed [34:0] den_reg, den_next;
    logic signed [63:0] num_reg;
    logic signed [34:0] ea_reg, eb_reg, ec_reg;
    logic signed [34:0] e0, e1, e2;
    logic signed [17:0] dx0, dy0, dx1, dy1, dx2, dy2;
    logic signed [17:0] x0, y0;
    logic [2:0]  upd_reg;
    logic [9:0]  rs_reg, gs_reg, bs_reg;
    logic [PW-1:0] pix_idx;
    logic [SampW-1:0] addr;
    logic [SampW-1:0] clr_reg, clr_next;
    logic signed [15:0] zq;
    logic        ddone;
    logic signed [15:0] depth_mem [0:PixCount*4-1];
    logic [23:0] color_mem [0:PixCount*4-1];
    logic signed [15:0] rd_depth_reg;
    logic [23:0] rd_color_reg;
    logic        wr_en;
    logic [SampW-1:0] wr_addr;
    logic signed [15:0] wr_depth;
    logic [23:0] wr_color;
    logic signed [17:0] sx, sy;
    logic signed [35:0] k1, k2, k3;
    logic        hit;
    logic [23:0] col;
    logic signed [63:0] p0, p1, p2;

    assign x0 = {2'b00, f_reg.pixel_x, 4'd0};
    assign y0 = {2'b00, f_reg.pixel_y, 4'd0};
    assign dx0 = 18'(f_reg.vert_b_y) - 18'(f_reg.vert_c_y);
    assign dy0 = 18'(f_reg.vert_c_x) - 18'(f_reg.vert_b_x);
    assign dx1 = 18'(f_reg.vert_c_y) - 18'(f_reg.vert_a_y);
    assign dy1 = 18'(f_reg.vert_a_x) - 18'(f_reg.vert_c_x);
    assign dx2 = 18'(f_reg.vert_a_y) - 18'(f_reg.vert_b_y);
    assign dy2 = 18'(f_reg.vert_b_x) - 18'(f_reg.vert_a_x);
    // edge functions relative to a point on each edge
    assign e0 = 35'(x0 - 18'(f_reg.vert_b_x)) * 35'(dx0) + 35'(y0 - 18'(f_reg.vert_b_y)) * 35'(dy0);
    assign e1 = 35'(x0 - 18'(f_reg.vert_c_x)) * 35'(dx1) + 35'(y0 - 18'(f_reg.vert_c_y)) * 35'(dy1);
    assign e2 = 35'(x0 - 18'(f_reg.vert_a_x)) * 35'(dx2) + 35'(y0 - 18'(f_reg.vert_a_y)) * 35'(dy2);
    assign den_next = 35'(18'(f_reg.vert_a_x) - 18'(f_reg.vert_b_x)) * 35'(dx0)
                    + 35'(18'(f_reg.vert_a_y) - 18'(f_reg.vert_b_y)) * 35'(dy0);

    assign pix_idx = PW'((ScreenHeight - 1 - int'(f_reg.pixel_y)) * ScreenWidth
                     + int'(f_reg.pixel_x));
    assign addr = {pix_idx, ctl.step};

    always_comb
    begin
        sx = x0 + 18'(ctl.step[1] ? 12 : 4);
        sy = y0 + 18'(ctl.step[0] ? 12 : 4);
        k1 = 36'(18'(f_reg.vert_a_x) - 18'(f_reg.vert_c_x)) * 36'(sy - 18'(f_reg.vert_a_y))
           - 36'(18'(f_reg.vert_a_y) - 18'(f_reg.vert_c_y)) * 36'(sx - 18'(f_reg.vert_a_x));
        k2 = 36'(18'(f_reg.vert_b_x) - 18'(f_reg.vert_a_x)) * 36'(sy - 18'(f_reg.vert_b_y))
           - 36'(18'(f_reg.vert_b_y) - 18'(f_reg.vert_a_y)) * 36'(sx - 18'(f_reg.vert_b_x));
        k3 = 36'(18'(f_reg.vert_c_x) - 18'(f_reg.vert_b_x)) * 36'(sy - 18'(f_reg.vert_c_y))
           - 36'(18'(f_reg.vert_c_y) - 18'(f_reg.vert_b_y)) * 36'(sx - 18'(f_reg.vert_c_x));
        hit = (zq > rd_depth_reg) && (k1[35] == k2[35]) && (k2[35] == k3[35]);
        col = hit ? f_reg.tri_color : rd_color_reg;
        clr_next = clr_reg + SampW'(1);
        // single write port shared by the clearing pass and the sample updates
        wr_en = (ctl.cmd == CMD_CLEAR) || ((ctl.cmd == CMD_SAMPLE) && hit);
        if (ctl.cmd == CMD_CLEAR)
        begin
            wr_addr = clr_reg;
            wr_depth = 16'sh8000;
            wr_color = 24'd0;
        end
        else
        begin
            wr_addr = addr;
            wr_depth = zq;
            wr_color = f_reg.tri_color;
        end
    end

    mzb_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (num_reg),
        .den   (64'(den_reg)),
        .done  (ddone),
        .quot  (zq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (ctl.cmd == CMD_CLEAR)
            clr_reg <= clr_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_READ)
        begin
            rd_depth_reg <= depth_mem[addr];
            rd_color_reg <= color_mem[addr];
        end
        if (wr_en)
        begin
            depth_mem[wr_addr] <= wr_depth;
            color_mem[wr_addr] <= wr_color;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.cmd)
            CMD_LOAD:
                f_reg <= frag_in;
            CMD_SETUP:
            begin
                den_reg <= den_next;
                ea_reg <= e0;
                eb_reg <= e1;
                ec_reg <= e2;
                if (ctl.step == 2'd1)
                    num_reg <= p0 + p1 + p2;
            end
            CMD_SAMPLE:
            begin
                if (ctl.step == 2'd0)
                begin
                    upd_reg <= {2'b00, hit};
                    rs_reg <= {2'b00, col[23:16]};
                    gs_reg <= {2'b00, col[15:8]};
                    bs_reg <= {2'b00, col[7:0]};
                end
                else
                begin
                    upd_reg <= upd_reg + {2'b00, hit};
                    rs_reg <= rs_reg + {2'b00, col[23:16]};
                    gs_reg <= gs_reg + {2'b00, col[15:8]};
                    bs_reg <= bs_reg + {2'b00, col[7:0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    // one multiplier per barycentric term, registered before the sum
    always_ff @(posedge clk)
    begin
        p0 <= 64'(ea_reg) * 64'(f_reg.vert_a_z);
        p1 <= 64'(eb_reg) * 64'(f_reg.vert_b_z);
        p2 <= 64'(ec_reg) * 64'(f_reg.vert_c_z);
    end

    assign sts.reject = (int'(f_reg.pixel_x) >= ScreenWidth) || (int'(f_reg.pixel_y) >= ScreenHeight)
                        || (den_next == 35'sd0);
    assign sts.div_done = ddone;
    assign sts.any_update = (upd_reg != 3'd0);
    assign sts.clear_done = &clr_reg;
    assign frag_out.out_x = f_reg.pixel_x;
    assign frag_out.out_y = f_reg.pixel_y;
    assign frag_out.red_sum = rs_reg;
    assign frag_out.green_sum = gs_reg;
    assign frag_out.blue_sum = bs_reg;
    assign frag_out.samples_updated = upd_reg;
endmodule

// ===== src/mzb_ctrl.sv =====
// controller: sequences clearing, load, setup, divide, four sample steps and output
// depends on mzb_pkg
module mzb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output mzb_pkg::dp_ctl_t ctl,
    input  mzb_pkg::dp_sts_t sts
);
    import mzb_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_SUM   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_READ  = 9'b001000000,
        S_SAMP  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        ctl.cmd = CMD_NONE;
        ctl.step = step_reg;
        ctl.div_start = 1'b0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.cmd = CMD_CLEAR;
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.cmd = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.cmd = CMD_SETUP;
                ctl.step = 2'd0;
                state_next = sts.reject ? S_IDLE : S_MUL;
            end
            S_MUL:
                state_next = S_SUM;
            S_SUM:
            begin
                ctl.cmd = CMD_SETUP;
                ctl.step = 2'd1;
                state_next = S_DIV;
                step_next = 2'd0;
            end
            S_DIV:
            begin
                if (step_reg == 2'd0)
                begin
                    ctl.div_start = 1'b1;
                    step_next = 2'd1;
                end
                else if (sts.div_done)
                begin
                    step_next = 2'd0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctl.cmd = CMD_READ;
                state_next = S_SAMP;
            end
            S_SAMP:
            begin
                ctl.cmd = CMD_SAMPLE;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = S_OUT;
                else
                    state_next = S_READ;
            end
            S_OUT:
            begin
                if (!sts.any_update)
                    state_next = S_IDLE;
                else
                begin
                    out_valid = 1'b1;
                    if (!out_stall)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end
endmodule

// ===== src/msaa_zbuffer_fragment.sv =====
// top level of the msaa z-buffer fragment block
// depends on mzb_pkg, mzb_ctrl, mzb_datapath
//
// channel | signals                        | payload
// in      | in_valid, in_stall             | in_data  (frag_in_t)
// out     | out_valid, out_stall           | out_data (frag_out_t)
//
// one pixel runs from its transfer through setup, the depth division (start, quotient bits,
// done), four samples of read then write on the sample memories and output, and only then
// can the next transfer come
// a degenerate triangle returns to idle from the check state, no result
// after reset a clearing pass writes all 262144 samples, one per cycle, input stalled
// a stalled output holds the block; input is stalled until the result leaves
module msaa_zbuffer_fragment
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mzb_pkg::frag_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mzb_pkg::frag_out_t out_data
);
    import mzb_pkg::*;

    dp_ctl_t ctl;
    dp_sts_t sts;

    mzb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    mzb_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .frag_in  (in_data),
        .ctl      (ctl),
        .sts      (sts),
        .frag_out (out_data)
    );
endmodule

// ===== src/mzb_checker.sv =====
// port checker for the msaa z-buffer fragment block
// depends on mzb_pkg and msaa_zbuffer_fragment_macros.svh
`include "msaa_zbuffer_fragment_macros.svh"
module mzb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input mzb_pkg::frag_in_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input mzb_pkg::frag_out_t out_data
);
    import mzb_pkg::*;

    `MZB_ASSERT_IMPL(a_busy_no_accept, out_valid, in_stall, "input taken while result pending")
    `MZB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `MZB_ASSERT_IMPL(a_upd_range, out_valid, out_data.samples_updated != 3'd0 && out_data.samples_updated <= 3'd4, "bad update count")
    `MZB_ASSERT_NEXT(a_accept_stall, in_valid && !in_stall, in_stall, "second transfer too soon")
    `MZB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled input changed")
endmodule

bind msaa_zbuffer_fragment mzb_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== test/msaa_zbuffer_fragment_tb.sv =====
// testbench for msaa_zbuffer_fragment: drives fragments, predicts sample updates, checks results
// depends on mzb_pkg and the msaa_zbuffer_fragment rtl
`timescale 1ns / 100ps

class frag_scoreboard;
    logic signed [15:0] depth_mem [int];
    logic [23:0]        color_mem [int];
    mzb_pkg::frag_out_t pending [$];
    int                 errors;

    function new();
        errors = 0;
    endfunction

    function automatic longint edge_fn(longint x, longint y, longint bx, longint by,
                                       longint cx, longint cy);
        return x * (by - cy) + (cx - bx) * y + bx * cy - cx * by;
    endfunction

    function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic logic signed [15:0] round_div(longint num, longint den);
        longint q;
        logic   neg;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        neg = num < 0;
        if (neg)
            num = -num;
        q = (num + den / 2) / den;
        if (neg)
            return (q >= 32768) ? 16'sh8000 : 16'(-q);
        return (q >= 32767) ? 16'sh7fff : 16'(q);
    endfunction

    function automatic void note_fragment(mzb_pkg::frag_in_t f);
        longint ax, ay, bx, by, cx, cy, x0, y0, den, num, sx, sy;
        logic signed [15:0] z, d;
        logic k1, k2, k3;
        int base, s, upd, r, g, b;
        mzb_pkg::frag_out_t o;
        ax = f.vert_a_x; ay = f.vert_a_y;
        bx = f.vert_b_x; by = f.vert_b_y;
        cx = f.vert_c_x; cy = f.vert_c_y;
        x0 = longint'(f.pixel_x) * 16;
        y0 = longint'(f.pixel_y) * 16;
        upd = 0; r = 0; g = 0; b = 0;
        den = edge_fn(ax, ay, bx, by, cx, cy);
        if (den == 0)
            return;
        num = edge_fn(x0, y0, bx, by, cx, cy) * longint'(f.vert_a_z)
            + edge_fn(x0, y0, cx, cy, ax, ay) * longint'(f.vert_b_z)
            + edge_fn(x0, y0, ax, ay, bx, by) * longint'(f.vert_c_z);
        z = round_div(num, den);
        base = ((255 - int'(f.pixel_y)) * 256 + int'(f.pixel_x)) * 4;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
            begin
                s = base + i * 2 + j;
                sx = x0 + i * 8 + 4;
                sy = y0 + j * 8 + 4;
                k1 = cross2(ax - cx, ay - cy, sx - ax, sy - ay) >= 0;
                k2 = cross2(bx - ax, by - ay, sx - bx, sy - by) >= 0;
                k3 = cross2(cx - bx, cy - by, sx - cx, sy - cy) >= 0;
                d = depth_mem.exists(s) ? depth_mem[s] : 16'sh8000;
                if (z > d && k1 == k2 && k2 == k3)
                begin
                    depth_mem[s] = z;
                    color_mem[s] = f.tri_color;
                    upd++;
                end
            end
        if (upd == 0)
            return;
        for (int k = 0; k < 4; k++)
            if (color_mem.exists(base + k))
            begin
                r += color_mem[base + k][23:16];
                g += color_mem[base + k][15:8];
                b += color_mem[base + k][7:0];
            end
        o.out_x = f.pixel_x;
        o.out_y = f.pixel_y;
        o.red_sum = 10'(r);
        o.green_sum = 10'(g);
        o.blue_sum = 10'(b);
        o.samples_updated = 3'(upd);
        pending.push_back(o);
    endfunction

    function automatic void check_result(mzb_pkg::frag_out_t got);
        mzb_pkg::frag_out_t exp;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected result %p", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got !== exp)
        begin
            $display("%0t mismatch expected %p actual %p", $time, exp, got);
            errors++;
        end
    endfunction
endclass

module msaa_zbuffer_fragment_tb;
    import mzb_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    frag_in_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    frag_out_t out_data;

    int send_idle = 0;
    int recv_idle = 0;
    longint cycle_count = 0;
    frag_scoreboard sb = new();

    msaa_zbuffer_fragment dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: check on transfer, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic send_fragment(frag_in_t f);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_fragment(f);
    endtask

    function automatic frag_in_t rand_fragment();
        frag_in_t f;
        logic [191:0] rnd;
        int x, y;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        f = rnd[$bits(frag_in_t)-1:0];
        if ($urandom_range(9) < 8)
        begin
            // small triangle around a pixel in a small region so pixels repeat
            x = $urandom_range(7);
            y = $urandom_range(7);
            f.pixel_x = 8'(x);
            f.pixel_y = 8'(y);
            f.vert_a_x = 16'(x * 16 + $urandom_range(80) - 40);
            f.vert_a_y = 16'(y * 16 + $urandom_range(80) - 40);
            f.vert_b_x = 16'(x * 16 + $urandom_range(80) - 40);
            f.vert_b_y = 16'(y * 16 + $urandom_range(80) - 40);
            f.vert_c_x = 16'(x * 16 + $urandom_range(80) - 40);
            f.vert_c_y = 16'(y * 16 + $urandom_range(80) - 40);
            f.vert_a_z = 16'($urandom_range(20000) - 10000);
            f.vert_b_z = 16'($urandom_range(20000) - 10000);
            f.vert_c_z = 16'($urandom_range(20000) - 10000);
        end
        return f;
    endfunction

    function automatic frag_in_t make_frag(int px, int py, int ax, int ay, int bx, int by,
                                           int cx, int cy, int az, int bz, int cz, int col);
        frag_in_t f;
        f.pixel_x = 8'(px);
        f.pixel_y = 8'(py);
        f.vert_a_x = 16'(ax); f.vert_a_y = 16'(ay); f.vert_a_z = 16'(az);
        f.vert_b_x = 16'(bx); f.vert_b_y = 16'(by); f.vert_b_z = 16'(bz);
        f.vert_c_x = 16'(cx); f.vert_c_y = 16'(cy); f.vert_c_z = 16'(cz);
        f.tri_color = 24'(col);
        return f;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 14;
        recv_idle = 74;
        // big triangle both windings, corners of the screen, extreme values
        send_fragment(make_frag(0, 0, -32768, -32768, 32767, -32768, -32768, 32767,
                                100, 100, 100, 24'hffffff));
        send_fragment(make_frag(0, 0, -32768, -32768, -32768, 32767, 32767, -32768,
                                200, 200, 200, 24'h123456));
        send_fragment(make_frag(255, 255, 0, 0, 8192, 0, 0, 8192, 32767, 32767, 32767,
                                24'hff00ff));
        send_fragment(make_frag(255, 0, 0, 0, 8192, 0, 0, 8192, -32768, -32768, -32768,
                                24'h00ff00));
        send_fragment(make_frag(0, 255, 0, 0, 8192, 0, 0, 8192, -32767, -32767, -32767,
                                24'h0000ff));
        // degenerate triangle
        send_fragment(make_frag(3, 3, 0, 0, 16, 16, 32, 32, 500, 500, 500, 24'haaaaaa));
        // partial coverage of a pixel by an edge through it
        send_fragment(make_frag(4, 4, 64, 64, 72, 64, 64, 96, 300, 300, 300, 24'h808080));
        send_fragment(make_frag(4, 4, 72, 64, 80, 96, 64, 96, 300, 300, 300, 24'h404040));
        // farther depth rejected, nearer replaces
        send_fragment(make_frag(4, 4, 0, 0, 4096, 0, 0, 4096, 100, 100, 100, 24'h010101));
        send_fragment(make_frag(4, 4, 0, 0, 4096, 0, 0, 4096, 400, 400, 400, 24'h020202));
        // triangle off the pixel
        send_fragment(make_frag(9, 9, 0, 0, 16, 0, 0, 16, 900, 900, 900, 24'hfefefe));
        // saturating depth, varying
        send_fragment(make_frag(1, 1, 0, 0, 64, 0, 0, 64, 32767, -32768, 32767, 24'h7f7f7f));
        send_fragment(make_frag(2, 1, 0, 0, 64, 0, 0, 64, -32768, 32767, -32768, 24'h800080));
        for (int n = 0; n < 150; n++)
            send_fragment(rand_fragment());
        send_idle = 74;
        recv_idle = 14;
        for (int n = 0; n < 150; n++)
            send_fragment(rand_fragment());
        send_idle = 0;
        recv_idle = 0;
        for (int n = 0; n < 150; n++)
            send_fragment(rand_fragment());
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== msaa_zbuffer_fragment.f =====
+incdir+src
src/mzb_pkg.sv
src/mzb_divider.sv
src/mzb_datapath.sv
src/mzb_ctrl.sv
src/msaa_zbuffer_fragment.sv
src/mzb_checker.sv
test/msaa_zbuffer_fragment_tb.sv
